### rtl/core/lwlc_pkg.sv
`timescale 1ns / 1ps

package lwlc_pkg;

    localparam int FRACTION_BITS = 8;

    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int NUM_TAPS  = 9;
    localparam int NUM_CH    = 3;
    localparam int NUM_LINKS = 8;
    localparam int LINK_W    = 3;

    localparam int IN_TDATA_W  = PIX_W * NUM_TAPS;
    localparam int IN_TUSER_W  = LINK_W;
    localparam int OUT_TDATA_W = 40;

    localparam int ACC_W = 11;
    localparam int MAG_W = 10;
    localparam int SQ_W  = 18;
    localparam int SUM_W = 20;
    localparam int Q3_W  = 18;

    // floor(x / 3) for x below 2^20 as (x * ceil(2^21 / 3)) >> 21
    localparam int DIV3_SHIFT  = 21;
    localparam int DIV3_MUL_W  = 21;
    localparam int DIV3_PROD_W = SUM_W + DIV3_MUL_W;
    localparam logic [DIV3_MUL_W-1:0] DIV3_MUL = 21'd699051;

    localparam int FRAC2_W = 2 * FRACTION_BITS;
    localparam longint unsigned THIRD_K_L = ((64'd1 << FRAC2_W) - 64'd1) / 3;
    localparam logic [FRAC2_W-1:0] THIRD_K = THIRD_K_L[FRAC2_W-1:0];

    localparam int EVEN_SHIFT = 4;
    localparam int ODD_SHIFT  = 1;

    localparam int RAD_W  = Q3_W + FRAC2_W;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    localparam int DERIV_W = 16;
    localparam int COST_W  = 17;
    localparam logic [DERIV_W-1:0] DERIV_MAX = 16'hFFFF;

    // floor(sqrt2 * 2^20) - 1, slightly low so the estimate never overshoots
    localparam int SQRT2_K_W   = 21;
    localparam int SQRT2_SHIFT = 20;
    localparam logic [SQRT2_K_W-1:0] SQRT2_K = 21'd1482909;
    localparam int PROD_W = DERIV_W + SQRT2_K_W;
    localparam int DSQ_W  = 2 * DERIV_W + 1;
    localparam int CSQ_W  = 2 * COST_W;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [DERIV_W-1:0] MAX_DERIV_RESET = 16'hFFFF;

    typedef enum logic {
        REG_MAX_DERIV = 1'b0
    } reg_idx_t;

    typedef enum logic [1:0] {
        W_ZERO = 2'b00,
        W_POS  = 2'b01,
        W_NEG  = 2'b11
    } weight_t;

    // taps: up_left, up, up_right, left, center, right, down_left, down, down_right
    localparam weight_t KERNEL_TAB [NUM_LINKS][NUM_TAPS] = '{
        '{W_ZERO, W_POS,  W_POS,  W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_NEG,  W_NEG },
        '{W_ZERO, W_NEG,  W_ZERO, W_ZERO, W_ZERO, W_POS,  W_ZERO, W_ZERO, W_ZERO},
        '{W_POS,  W_ZERO, W_NEG,  W_POS,  W_ZERO, W_NEG,  W_ZERO, W_ZERO, W_ZERO},
        '{W_ZERO, W_POS,  W_ZERO, W_NEG,  W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO},
        '{W_POS,  W_POS,  W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_NEG,  W_NEG,  W_ZERO},
        '{W_ZERO, W_ZERO, W_ZERO, W_NEG,  W_ZERO, W_ZERO, W_ZERO, W_POS,  W_ZERO},
        '{W_ZERO, W_ZERO, W_ZERO, W_POS,  W_ZERO, W_NEG,  W_POS,  W_ZERO, W_NEG },
        '{W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_ZERO, W_NEG,  W_ZERO, W_POS,  W_ZERO}
    };

    typedef struct packed {
        logic valid;
        logic odd;
    } ctl_t;

    typedef struct packed {
        logic [COST_W-1:0]  cost;
        logic [DERIV_W-1:0] deriv;
    } result_t;

endpackage

### rtl/core/lwlc_kernel.sv
`timescale 1ns / 1ps

module lwlc_kernel
    import lwlc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  in_valid,
    input  logic [IN_TDATA_W-1:0] in_pix,
    input  logic [LINK_W-1:0]     in_link,
    output ctl_t                  out_ctl,
    output logic [RAD_W-1:0]      out_rad
);

    ctl_t                      ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg, ctl5_reg;
    logic signed [ACC_W-1:0]   acc_reg [NUM_CH];
    logic signed [ACC_W-1:0]   acc_next [NUM_CH];
    logic [SQ_W-1:0]           sq_reg [NUM_CH];
    logic [SQ_W-1:0]           sq_next [NUM_CH];
    logic [SUM_W-1:0]          sum_reg, sum4_reg;
    logic [Q3_W-1:0]           q3_reg;
    logic [DIV3_PROD_W-1:0]    div_prod;
    logic [SUM_W-1:0]          rem3;
    logic [FRAC2_W-1:0]        rem_k;
    logic [RAD_W-1:0]          scaled3;
    logic [RAD_W-1:0]          rad_reg, rad_next;

    // channel kernel sums
    always_comb
    begin
        logic signed [ACC_W-1:0] px;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            acc_next[ch] = '0;
            for (int t = 0; t < NUM_TAPS; t++)
            begin
                px = ACC_W'($signed({1'b0, in_pix[t*PIX_W + ch*CH_W +: CH_W]}));
                case (KERNEL_TAB[in_link][t])
                    W_POS:   acc_next[ch] = acc_next[ch] + px;
                    W_NEG:   acc_next[ch] = acc_next[ch] - px;
                    default: acc_next[ch] = acc_next[ch];
                endcase
            end
        end
    end

    // squared magnitudes
    always_comb
    begin
        logic [ACC_W-1:0] mag;
        for (int ch = 0; ch < NUM_CH; ch++)
        begin
            mag = acc_reg[ch][ACC_W-1] ? ACC_W'(-acc_reg[ch]) : ACC_W'(acc_reg[ch]);
            sq_next[ch] = SQ_W'(mag[MAG_W-1:0] * mag[MAG_W-1:0]);
        end
    end

    assign div_prod = DIV3_PROD_W'(sum_reg) * DIV3_PROD_W'(DIV3_MUL);

    // sum * 2^2F / 3 split as (q3 << 2F) + r * (2^2F - 1) / 3
    always_comb
    begin
        rem3 = sum4_reg - SUM_W'({q3_reg, 1'b0}) - SUM_W'(q3_reg);
        case (rem3[1:0])
            2'd1:    rem_k = THIRD_K;
            2'd2:    rem_k = {THIRD_K[FRAC2_W-2:0], 1'b0};
            default: rem_k = '0;
        endcase
        scaled3  = {q3_reg, rem_k};
        rad_next = ctl4_reg.odd ? (scaled3 >> ODD_SHIFT) : (scaled3 >> EVEN_SHIFT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
            ctl5_reg <= '0;
        end
        else if (advance)
        begin
            ctl1_reg <= '{valid: in_valid, odd: in_link[0]};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
            ctl5_reg <= ctl4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                acc_reg[ch] <= acc_next[ch];
                sq_reg[ch]  <= sq_next[ch];
            end
            sum_reg  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            q3_reg   <= div_prod[DIV3_SHIFT +: Q3_W];
            sum4_reg <= sum_reg;
            rad_reg  <= rad_next;
        end
    end

    assign out_ctl = ctl5_reg;
    assign out_rad = rad_reg;

endmodule

### rtl/core/lwlc_sqrt.sv
`timescale 1ns / 1ps

module lwlc_sqrt
    import lwlc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  ctl_t              in_ctl,
    input  logic [RAD_W-1:0]  in_rad,
    output ctl_t              out_ctl,
    output logic [ROOT_W-1:0] out_root
);

    ctl_t              ctl_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W-1];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W-1];

    ctl_t              st_ctl  [ROOT_W];
    logic [ROOT_W-1:0] st_root [ROOT_W];
    logic [REM_W-1:0]  st_rem  [ROOT_W];
    logic [RAD_W-1:0]  st_rad  [ROOT_W];

    assign st_ctl[0]  = in_ctl;
    assign st_root[0] = '0;
    assign st_rem[0]  = '0;
    assign st_rad[0]  = in_rad;

    // one result bit per stage, two radicand bits consumed per stage
    for (genvar j = 0; j < ROOT_W; j++)
    begin : g_stage
        logic [REM_W-1:0] rem_sh;
        logic [REM_W-1:0] trial;
        logic             bit_set;

        assign rem_sh  = {st_rem[j][REM_W-3:0], st_rad[j][RAD_W-1 -: 2]};
        assign trial   = {st_root[j], 2'b01};
        assign bit_set = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[j] <= '0;
            end
            else if (advance)
            begin
                ctl_reg[j] <= st_ctl[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                root_reg[j] <= {st_root[j][ROOT_W-2:0], bit_set};
            end
        end

        if (j < ROOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    rem_reg[j] <= bit_set ? (rem_sh - trial) : rem_sh;
                    rad_reg[j] <= {st_rad[j][RAD_W-3:0], 2'b00};
                end
            end

            assign st_ctl[j+1]  = ctl_reg[j];
            assign st_root[j+1] = root_reg[j];
            assign st_rem[j+1]  = rem_reg[j];
            assign st_rad[j+1]  = rad_reg[j];
        end
    end

    assign out_ctl  = ctl_reg[ROOT_W-1];
    assign out_root = root_reg[ROOT_W-1];

endmodule

### rtl/core/lwlc_cost.sv
`timescale 1ns / 1ps

module lwlc_cost
    import lwlc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic [DERIV_W-1:0] max_deriv,
    input  ctl_t               in_ctl,
    input  logic [ROOT_W-1:0]  in_root,
    output ctl_t               out_ctl,
    output result_t            out_res
);

    localparam int WIDE_W = ROOT_W + DERIV_W;

    ctl_t               ctl1_reg, ctl2_reg, ctl3_reg;
    logic [WIDE_W-1:0]  root_wide;
    logic [DERIV_W-1:0] deriv_sat;
    logic [DERIV_W-1:0] deriv1_reg, deriv2_reg, deriv3_reg;
    logic [DERIV_W-1:0] diff1_reg, diff2_reg, diff3_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [DSQ_W-1:0]   dsq2_reg, dsq3_reg;
    logic [COST_W-1:0]  cand;
    logic [COST_W-1:0]  cand_up;
    logic [COST_W-1:0]  cand_reg;
    logic [CSQ_W-1:0]   csq_reg;
    logic [COST_W-1:0]  cost;

    assign root_wide = WIDE_W'(in_root);
    assign deriv_sat = (root_wide > WIDE_W'(DERIV_MAX)) ? DERIV_MAX : root_wide[DERIV_W-1:0];

    // estimate floor(diff * sqrt2), then bump by one where the square allows
    assign cand    = prod_reg[SQRT2_SHIFT +: COST_W];
    assign cand_up = cand + COST_W'(1);

    always_comb
    begin
        if (!ctl3_reg.odd)
        begin
            cost = COST_W'(diff3_reg);
        end
        else if (DSQ_W'(csq_reg) <= dsq3_reg)
        begin
            cost = cand_reg + COST_W'(1);
        end
        else
        begin
            cost = cand_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
        end
        else if (advance)
        begin
            ctl1_reg <= in_ctl;
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            deriv1_reg <= deriv_sat;
            diff1_reg  <= (max_deriv > deriv_sat) ? (max_deriv - deriv_sat) : '0;

            deriv2_reg <= deriv1_reg;
            diff2_reg  <= diff1_reg;
            prod_reg   <= PROD_W'(diff1_reg) * PROD_W'(SQRT2_K);
            dsq2_reg   <= (DSQ_W'(diff1_reg) * DSQ_W'(diff1_reg)) << 1;

            deriv3_reg <= deriv2_reg;
            diff3_reg  <= diff2_reg;
            dsq3_reg   <= dsq2_reg;
            cand_reg   <= cand;
            csq_reg    <= CSQ_W'(cand_up) * CSQ_W'(cand_up);
        end
    end

    assign out_ctl = ctl3_reg;
    assign out_res = '{cost: cost, deriv: deriv3_reg};

endmodule

### rtl/core/lwlc_out_buf.sv
`timescale 1ns / 1ps

module lwlc_out_buf
    import lwlc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  ctl_t    in_ctl,
    input  result_t in_res,
    output logic    advance,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_res_reg, out_res_next;
    result_t skid_res_reg, skid_res_next;
    logic    push;

    // pipeline moves only while the skid slot is free
    assign advance = !skid_valid_reg;
    assign push    = advance && in_ctl.valid;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_res_next    = out_res_reg;
        skid_res_next   = skid_res_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_res_next    = skid_res_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = push;
                out_res_next   = in_res;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_res_next   = in_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_res_reg  <= out_res_next;
        skid_res_reg <= skid_res_next;
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

endmodule

### rtl/core/live_wire_link_cost.sv
`timescale 1ns / 1ps

// Live-wire link cost. Each input item carries the 3x3 RGB neighbourhood of a
// pixel in s_axis_tdata and a link index (0..7) in s_axis_tuser; each output
// item carries the RMS directional derivative (unsigned Q8.8) and the refined
// link cost (Q9.8, times sqrt2 on odd links, floored at zero) computed
// against the max_derivative register at APB byte address 0 (reset 0xFFFF).
// The block accepts one item per clock while s_axis_tready is high and
// returns one result per item in order. Items pass through 5 kernel stages,
// one stage per root bit (9 + FRACTION_BITS, 17 for Q8.8), 3 cost stages
// and the output register. s_axis_tready drops only while a result waits in
// the skid slot behind a stalled output; max_derivative should be written only
// while no items are in flight.

module live_wire_link_cost
    import lwlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // pix_up_left, pix_up, pix_up_right, pix_left, pix_center, pix_right,
    // pix_down_left, pix_down, pix_down_right
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // link
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,

    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // derivative, refined_cost, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    output logic [CFG_DATA_W-1:0]  prdata,
    output logic                   pready
);

    logic [DERIV_W-1:0] max_deriv_reg;
    logic               advance;
    ctl_t               kern_ctl, root_ctl, cost_ctl;
    logic [RAD_W-1:0]   kern_rad;
    logic [ROOT_W-1:0]  root_val;
    result_t            cost_res, out_res;
    logic               reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == REG_MAX_DERIV);
    assign prdata  = reg_hit ? CFG_DATA_W'(max_deriv_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_deriv_reg <= MAX_DERIV_RESET;
        end
        else if (psel && penable && pwrite && pready && reg_hit)
        begin
            max_deriv_reg <= pwdata[DERIV_W-1:0];
        end
    end

    assign s_axis_tready = advance;

    lwlc_kernel u_kernel (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_valid (s_axis_tvalid),
        .in_pix   (s_axis_tdata),
        .in_link  (s_axis_tuser),
        .out_ctl  (kern_ctl),
        .out_rad  (kern_rad)
    );

    lwlc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .in_ctl   (kern_ctl),
        .in_rad   (kern_rad),
        .out_ctl  (root_ctl),
        .out_root (root_val)
    );

    lwlc_cost u_cost (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .max_deriv (max_deriv_reg),
        .in_ctl    (root_ctl),
        .in_root   (root_val),
        .out_ctl   (cost_ctl),
        .out_res   (cost_res)
    );

    lwlc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (cost_ctl),
        .in_res    (cost_res),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res)
    );

    assign m_axis_tdata = {(OUT_TDATA_W - COST_W - DERIV_W)'(0), out_res};

endmodule

### rtl/core/lwlc_checker.sv
`timescale 1ns / 1ps

module lwlc_checker
    import lwlc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tready,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_ADDR_W-1:0]  paddr,
    input  logic [CFG_DATA_W-1:0]  pwdata,
    input  logic [CFG_DATA_W-1:0]  prdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    // input backpressure only with a result waiting at the output
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with empty output");

    // register write is visible on the next read
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && !paddr[2]) ##1 (psel && !pwrite && !paddr[2])
        |-> prdata[DERIV_W-1:0] == $past(pwdata[DERIV_W-1:0]))
        else $error("max_derivative readback mismatch");

    // unused read bits stay zero
    a_cfg_upper: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> prdata[CFG_DATA_W-1:DERIV_W] == '0)
        else $error("nonzero upper read bits");

endmodule

bind live_wire_link_cost lwlc_checker u_lwlc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata)
);
